[sv/piuw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piuw_pkg - shared types and constants for the palette upscale writer
// Palette table, register indexes, field widths and the handshake structs
// between controller and datapath.
// ----------------------------------------------------------------------------
package piuw_pkg;

	// defaults for the top-level parameters
	localparam int DEF_CANVAS_WIDTH  = 320;
	localparam int DEF_CANVAS_HEIGHT = 200;
	localparam int DEF_MAX_SCALE     = 8;

	// field widths
	localparam int ADDR_W     = 48;
	localparam int RGB_W      = 24;
	localparam int PIX_W      = 14;   // frame size and real pixel coordinates
	localparam int PITCH_W    = 16;
	localparam int BPP_W      = 6;
	localparam int STRIDE_W   = 3;    // bits_per_pixel / 8
	localparam int SC_W       = 4;    // scale, 1 to 8
	localparam int XOFF_W     = PIX_W + STRIDE_W;
	localparam int YOFF_W     = PIX_W + PITCH_W;
	localparam int CIDX_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	localparam logic [BPP_W-1:0] BPP_RESET = 6'd32;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_BASE     = 3'd0,
		REG_FRAME_WIDTH    = 3'd1,
		REG_FRAME_HEIGHT   = 3'd2,
		REG_ROW_PITCH      = 3'd3,
		REG_BITS_PER_PIXEL = 3'd4
	} cfg_reg_t;

	// fixed 16-colour palette, red in the top byte, entry 0 in the low bits
	localparam logic [15:0][RGB_W-1:0] PALETTE = {
		24'hFFFFFF, 24'hFFFF55, 24'hFF55FF, 24'hFF5555,
		24'h55FFFF, 24'h55FF55, 24'h5555FF, 24'h555555,
		24'hAAAAAA, 24'hAA5500, 24'hAA00AA, 24'hAA0000,
		24'h00AAAA, 24'h00AA00, 24'h0000AA, 24'h000000
	};

	typedef struct packed {
		logic [ADDR_W-1:0]  base;
		logic [PIX_W-1:0]   width;
		logic [PIX_W-1:0]   height;
		logic [PITCH_W-1:0] pitch;
		logic [BPP_W-1:0]   bpp;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_SETUP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;    // take the word, latch origin and scales
		logic mul;     // form row and column offsets
		logic setup;   // form the first row address
		logic emit;    // load one write into the output register
	} dp_cmd_t;

	typedef struct packed {
		logic empty;     // nothing to write for this pixel
		logic out_free;  // output register can take a word
		logic last;      // current write is the final one
	} dp_status_t;

	// integer scale size / canvas, clamped to 1..max_scale and at most 8, by compares only
	function automatic logic [SC_W-1:0] scale_of(input logic [PIX_W-1:0] size,
			input int canvas, input int max_scale);
		logic [SC_W-1:0] s;
		s = SC_W'(1);
		for (int k = 2; k <= 8; k++) begin
			if (k <= max_scale && 32'(size) >= 32'(k * canvas))
				s = SC_W'(k);
		end
		return s;
	endfunction

endpackage

[sv/piuw_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piuw_cfg - configuration registers
// Write-only register file; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module piuw_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write_en,
	input  logic [piuw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [piuw_pkg::CFG_DATA_W-1:0]   cfg_data,
	output piuw_pkg::cfg_t                    cfg
);
	import piuw_pkg::*;

	cfg_t cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base   <= '0;
			cfg_q.width  <= '0;
			cfg_q.height <= '0;
			cfg_q.pitch  <= '0;
			cfg_q.bpp    <= BPP_RESET;
		end else if (cfg_write_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_BASE:     cfg_q.base   <= cfg_data[ADDR_W-1:0];
				REG_FRAME_WIDTH:    cfg_q.width  <= cfg_data[PIX_W-1:0];
				REG_FRAME_HEIGHT:   cfg_q.height <= cfg_data[PIX_W-1:0];
				REG_ROW_PITCH:      cfg_q.pitch  <= cfg_data[PITCH_W-1:0];
				REG_BITS_PER_PIXEL: cfg_q.bpp    <= cfg_data[BPP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/piuw_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piuw_ctrl - sequencing state machine
// Takes one canvas word, walks the datapath through offset set-up and then
// one write per cycle when out_free, until the block of real pixels is done.
// ----------------------------------------------------------------------------
module piuw_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  piuw_pkg::dp_status_t  status,
	output piuw_pkg::dp_cmd_t     cmd
);
	import piuw_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = status.empty ? ST_IDLE : ST_SETUP;
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.last)
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[sv/piuw_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piuw_dp - address and colour datapath
// Canvas position, scale, offset products, running row/column addresses,
// clip tests and the output register.
// ----------------------------------------------------------------------------
module piuw_dp #(
	parameter int CANVAS_WIDTH  = piuw_pkg::DEF_CANVAS_WIDTH,
	parameter int CANVAS_HEIGHT = piuw_pkg::DEF_CANVAS_HEIGHT,
	parameter int MAX_SCALE     = piuw_pkg::DEF_MAX_SCALE
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  piuw_pkg::cfg_t                  cfg,
	input  piuw_pkg::dp_cmd_t               cmd,
	output piuw_pkg::dp_status_t            status,
	input  logic [piuw_pkg::CIDX_W-1:0]     color_index,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [piuw_pkg::ADDR_W-1:0]     write_address,
	output logic [piuw_pkg::RGB_W-1:0]      pixel_rgb,
	output logic                            last_write
);
	import piuw_pkg::*;

	localparam int COL_W = (CANVAS_WIDTH  > 1) ? $clog2(CANVAS_WIDTH)  : 1;
	localparam int ROW_W = (CANVAS_HEIGHT > 1) ? $clog2(CANVAS_HEIGHT) : 1;

	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic [RGB_W-1:0]    rgb_q;
	logic [SC_W-1:0]     sx_q, sy_q, dx_q, dy_q;
	logic [PIX_W-1:0]    phx0_q, phy0_q, phx_q, phy_q;
	logic [YOFF_W-1:0]   yoff_q;
	logic [XOFF_W-1:0]   xoff0_q, xoff_q;
	logic [ADDR_W-1:0]   row_addr_q;
	logic                out_valid_q;
	logic [ADDR_W-1:0]   out_addr_q;
	logic [RGB_W-1:0]    out_rgb_q;
	logic                out_last_q;

	logic [SC_W-1:0]     sx_c, sy_c;
	logic [STRIDE_W-1:0] stride;
	logic                x_end, y_end;

	assign sx_c   = scale_of(cfg.width,  CANVAS_WIDTH,  MAX_SCALE);
	assign sy_c   = scale_of(cfg.height, CANVAS_HEIGHT, MAX_SCALE);
	assign stride = cfg.bpp[BPP_W-1:3];

	// canvas position, advanced on every word taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.load) begin
			if (col_q == COL_W'(CANVAS_WIDTH - 1)) begin
				col_q <= '0;
				row_q <= (row_q == ROW_W'(CANVAS_HEIGHT - 1)) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// per-pixel set-up: origin, offsets, running position
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rgb_q  <= PALETTE[color_index[3:0]];
			sx_q   <= sx_c;
			sy_q   <= sy_c;
			phx0_q <= PIX_W'(PIX_W'(col_q) * PIX_W'(sx_c));
			phy0_q <= PIX_W'(PIX_W'(row_q) * PIX_W'(sy_c));
		end
		if (cmd.mul) begin
			yoff_q  <= YOFF_W'(phy0_q) * YOFF_W'(cfg.pitch);
			xoff0_q <= XOFF_W'(phx0_q) * XOFF_W'(stride);
		end
		if (cmd.setup) begin
			row_addr_q <= cfg.base + ADDR_W'(yoff_q);
			xoff_q     <= xoff0_q;
			phx_q      <= phx0_q;
			phy_q      <= phy0_q;
			dx_q       <= '0;
			dy_q       <= '0;
		end else if (cmd.emit) begin
			if (x_end) begin
				// next row of the block
				row_addr_q <= row_addr_q + ADDR_W'(cfg.pitch);
				xoff_q     <= xoff0_q;
				phx_q      <= phx0_q;
				phy_q      <= phy_q + 1'b1;
				dx_q       <= '0;
				dy_q       <= dy_q + 1'b1;
			end else begin
				xoff_q <= xoff_q + XOFF_W'(stride);
				phx_q  <= phx_q + 1'b1;
				dx_q   <= dx_q + 1'b1;
			end
		end
	end

	// end of row and end of block, clipping included
	assign x_end = (dx_q == sx_q - 1'b1) || ({1'b0, phx_q} + 1'b1 >= {1'b0, cfg.width});
	assign y_end = (dy_q == sy_q - 1'b1) || ({1'b0, phy_q} + 1'b1 >= {1'b0, cfg.height});

	assign status.empty    = (cfg.base == '0) || (phx0_q >= cfg.width)
			|| (phy0_q >= cfg.height);
	assign status.out_free = !out_valid_q || out_ready;
	assign status.last     = x_end && y_end;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_addr_q <= row_addr_q + ADDR_W'(xoff_q);
			out_rgb_q  <= rgb_q;
			out_last_q <= status.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign write_address = out_addr_q;
	assign pixel_rgb     = out_rgb_q;
	assign last_write    = out_last_q;

	// a write never overruns a word still waiting
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("write issued over an untaken word");

	// block counters stay inside the scale
	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (dx_q < sx_q && dy_q < sy_q))
		else $error("block counter past scale");

	// clipped pixels are never written
	a_emit_clip: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (phx_q < cfg.width && phy_q < cfg.height))
		else $error("write outside the framebuffer");

	// a zero base suppresses every write
	a_emit_base: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (cfg.base != '0))
		else $error("write with zero base address");

endmodule

[sv/palette_integer_upscale_writer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_integer_upscale_writer_unit - palette lookup and integer upscaler
// Turns raster-order canvas colour indexes into framebuffer writes.
// ----------------------------------------------------------------------------
// Each canvas word is looked up in the 16-colour palette and widened into a
// block of scale_x by scale_y framebuffer writes, row by row, with pixels
// outside the framebuffer dropped and no writes at all while the base address
// is zero. A word passes through a step that latches it and its scales, a step
// for the offset multiplies and a step for the first row address, then one
// write per cycle from the output register while it can take one; a word
// with no writes ends after the multiplies. The write stream stalls only on
// out_ready. Registers should be written while no word is in flight.
// ----------------------------------------------------------------------------
module palette_integer_upscale_writer_unit #(
	parameter int CANVAS_WIDTH  = piuw_pkg::DEF_CANVAS_WIDTH,
	parameter int CANVAS_HEIGHT = piuw_pkg::DEF_CANVAS_HEIGHT,
	parameter int MAX_SCALE     = piuw_pkg::DEF_MAX_SCALE
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic [piuw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [piuw_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [piuw_pkg::CIDX_W-1:0]      color_index,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [piuw_pkg::ADDR_W-1:0]      write_address,
	output logic [piuw_pkg::RGB_W-1:0]       pixel_rgb,
	output logic                             last_write
);
	import piuw_pkg::*;

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t status;

	piuw_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cfg          (cfg)
	);

	piuw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	piuw_dp #(
		.CANVAS_WIDTH  (CANVAS_WIDTH),
		.CANVAS_HEIGHT (CANVAS_HEIGHT),
		.MAX_SCALE     (MAX_SCALE)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.status        (status),
		.color_index   (color_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.write_address (write_address),
		.pixel_rgb     (pixel_rgb),
		.last_write    (last_write)
	);

endmodule

[bench/palette_integer_upscale_writer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_integer_upscale_writer_unit_tb - self-checking bench for the upscaler
// Streams canvas colour indexes into the block and checks every framebuffer
// write against a scoreboard filled by a behavioural predictor. Directed
// tests cover reset state, the palette, scale and address extremes, clipping
// and spare register indexes; random phases follow.
// ----------------------------------------------------------------------------
module palette_integer_upscale_writer_unit_tb;

	import piuw_pkg::*;

	localparam int CANVAS_W        = DEF_CANVAS_WIDTH;
	localparam int CANVAS_H        = DEF_CANVAS_HEIGHT;
	localparam int MAX_SC          = DEF_MAX_SCALE;
	localparam int IDLE_TAIL       = 8;
	localparam int RAND_PHASES     = 6;
	localparam int WORDS_PER_PHASE = 16;
	localparam longint RUN_LIMIT_NS = 20_000_000;

	localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_REG = CFG_IDX_W'(REG_BITS_PER_PIXEL) + 1'b1;

	// 16-colour palette, entry 0 in the low bits
	localparam logic [16*RGB_W-1:0] VGA_RGB = {
		24'hFFFFFF, 24'hFFFF55, 24'hFF55FF, 24'hFF5555,
		24'h55FFFF, 24'h55FF55, 24'h5555FF, 24'h555555,
		24'hAAAAAA, 24'hAA5500, 24'hAA00AA, 24'hAA0000,
		24'h00AAAA, 24'h00AA00, 24'h0000AA, 24'h000000
	};

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [RGB_W-1:0]  rgb;
		logic              is_last;
	} fb_write_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_ready;
	logic [CIDX_W-1:0]     color_index  = '0;
	logic                  out_valid;
	logic                  out_ready    = 1'b0;
	logic [ADDR_W-1:0]     write_address;
	logic [RGB_W-1:0]      pixel_rgb;
	logic                  last_write;

	// shadow registers and canvas position
	logic [ADDR_W-1:0] fb_base    = '0;
	int                cur_width  = 0;
	int                cur_height = 0;
	int                cur_pitch  = 0;
	int                fb_bpp     = int'(BPP_RESET);
	int                canvas_x   = 0;
	int                canvas_y   = 0;

	fb_write_t pending_writes[$];
	int        err_count  = 0;
	bit        gaps_on    = 1'b1;
	int        stall_pct  = 20;
	int        stall_left = 0;

	palette_integer_upscale_writer_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.color_index   (color_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.write_address (write_address),
		.pixel_rgb     (pixel_rgb),
		.last_write    (last_write)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic int scale_for(input int size, input int canvas);
		int s;
		s = size / canvas;
		if (s < 1) s = 1;
		if (s > MAX_SC) s = MAX_SC;
		return s;
	endfunction

	// queue the writes one canvas word causes and step the position
	function automatic void plan_writes(input logic [CIDX_W-1:0] ci);
		fb_write_t w;
		int vx, vy, sx, sy, n;
		longint phx, phy;
		vx = canvas_x;
		vy = canvas_y;
		canvas_x = canvas_x + 1;
		if (canvas_x >= CANVAS_W) begin
			canvas_x = 0;
			canvas_y = (canvas_y + 1 >= CANVAS_H) ? 0 : canvas_y + 1;
		end
		if (fb_base == '0) return;
		sx = scale_for(cur_width, CANVAS_W);
		sy = scale_for(cur_height, CANVAS_H);
		n = 0;
		w.rgb = VGA_RGB[ci[3:0]*RGB_W +: RGB_W];
		w.is_last = 1'b0;
		for (int dy = 0; dy < sy; dy++) begin
			phy = longint'(vy) * sy + dy;
			if (phy >= cur_height) break;
			for (int dx = 0; dx < sx; dx++) begin
				phx = longint'(vx) * sx + dx;
				if (phx >= cur_width) break;
				w.addr = fb_base + ADDR_W'(phy * cur_pitch + phx * (fb_bpp / 8));
				pending_writes.push_back(w);
				n++;
			end
		end
		if (n > 0) pending_writes[pending_writes.size()-1].is_last = 1'b1;
	endfunction

	// idle length: mostly short, now and then long
	function automatic int idle_len();
		return ($urandom_range(9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
	endfunction

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= val;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		case (idx)
			REG_FRAME_BASE:     fb_base    = val[ADDR_W-1:0];
			REG_FRAME_WIDTH:    cur_width  = int'(val[PIX_W-1:0]);
			REG_FRAME_HEIGHT:   cur_height = int'(val[PIX_W-1:0]);
			REG_ROW_PITCH:      cur_pitch  = int'(val[PITCH_W-1:0]);
			REG_BITS_PER_PIXEL: fb_bpp     = int'(val[BPP_W-1:0]);
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_frame(input logic [ADDR_W-1:0] base, input int width, input int height,
			input int pitch, input int bpp);
		write_reg(REG_FRAME_BASE, CFG_DATA_W'(base));
		write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(width));
		write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(height));
		write_reg(REG_ROW_PITCH, CFG_DATA_W'(pitch));
		write_reg(REG_BITS_PER_PIXEL, CFG_DATA_W'(bpp));
	endtask

	// offer one canvas word, returns at the edge that takes it
	task automatic push_pixel(input logic [CIDX_W-1:0] ci);
		int gap;
		gap = (gaps_on && $urandom_range(99) < 35) ? idle_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		color_index <= ci;
		do @(posedge clk); while (!in_ready);
		plan_writes(ci);
	endtask

	// drop valid and wait for the write stream to drain
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_writes.size() != 0) @(posedge clk);
		repeat (IDLE_TAIL) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_reset_state();
		// base is zero out of reset: no writes
		push_pixel(8'h00);
		push_pixel(8'hFF);
		settle();
		// base set but width still zero: every pixel clipped
		write_reg(REG_FRAME_BASE, 48'h0000_0040_0000);
		push_pixel(8'h0C);
		settle();
		// pixel depth left at its reset value
		write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(640));
		write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(400));
		write_reg(REG_ROW_PITCH, CFG_DATA_W'(2560));
		push_pixel(8'hA5);
		settle();
	endtask

	task automatic test_palette();
		logic [CIDX_W-1:0] ci;
		set_frame(48'h0000_1000_0000, 640, 400, 2560, 32);
		for (int i = 0; i < 16; i++) begin
			ci = {4'($urandom), 4'(i)};
			if (i == 0) ci = '0;
			if (i == 15) ci = '1;
			push_pixel(ci);
		end
		settle();
	endtask

	task automatic test_scale_extremes();
		// 8x8 block, top of address space, widest stride
		set_frame(48'hFFFF_FFFF_FFFF, (1 << PIX_W) - 1, (1 << PIX_W) - 1, 16'hFFFF, 63);
		push_pixel(8'h3E);
		settle();
		// 3x3 with depth under a byte: zero stride
		set_frame(48'h0000_0000_0001, 960, 600, 1280, 7);
		push_pixel(8'hC9);
		settle();
		// 1x1, zero pitch and zero depth
		set_frame(48'h0000_0000_ABCD, 320, 200, 0, 0);
		push_pixel(8'h71);
		settle();
		// zero-sized framebuffer clips everything
		set_frame(48'h0000_0000_0010, 0, 0, 1024, 32);
		push_pixel(8'h8B);
		settle();
	endtask

	task automatic test_clipping();
		// right-hand clip passes across the current column
		set_frame(48'h0000_2000_0000, canvas_x + 2, 1, 1024, 16);
		repeat (4) push_pixel(CIDX_W'($urandom));
		settle();
		// narrow but tall: 1x2 block on the right-hand edge, then clipped
		write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(canvas_x + 1));
		write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(400));
		write_reg(REG_BITS_PER_PIXEL, CFG_DATA_W'(32));
		push_pixel(8'h27);
		push_pixel(8'h92);
		settle();
	endtask

	task automatic test_spare_index();
		set_frame(48'h0000_3000_0000, 640, 400, 2560, 24);
		for (int k = FIRST_SPARE_REG; k < (1 << CFG_IDX_W); k++)
			write_reg(CFG_IDX_W'(k), '1);
		push_pixel(8'hE6);
		push_pixel(8'h19);
		settle();
	endtask

	function automatic int pick_size(input int canvas);
		case ($urandom_range(9))
			0:       return $urandom_range(canvas - 1);
			1:       return (1 << PIX_W) - 1;
			default: return canvas * $urandom_range(1, 3) + $urandom_range(canvas - 1);
		endcase
	endfunction

	task automatic test_random_traffic();
		logic [63:0]       r;
		logic [ADDR_W-1:0] base;
		int                pitch, bpp;
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			r = {$urandom, $urandom};
			case ($urandom_range(7))
				0:       base = '0;
				1:       base = {32'hFFFF_FFFF, r[15:0]};
				default: base = (r[ADDR_W-1:0] == '0) ? ADDR_W'(1) : r[ADDR_W-1:0];
			endcase
			case ($urandom_range(5))
				0:       pitch = 0;
				1:       pitch = (1 << PITCH_W) - 1;
				default: pitch = $urandom_range((1 << PITCH_W) - 1);
			endcase
			bpp = ($urandom_range(3) == 0) ? $urandom_range((1 << BPP_W) - 1)
				: 8 * $urandom_range(1, 4);
			set_frame(base, pick_size(CANVAS_W), pick_size(CANVAS_H), pitch, bpp);
			// some phases run flat out on both sides
			gaps_on = ($urandom_range(3) != 0);
			case ($urandom_range(2))
				0:       stall_pct = 0;
				1:       stall_pct = 10;
				default: stall_pct = 35;
			endcase
			repeat (WORDS_PER_PHASE) push_pixel(CIDX_W'($urandom));
			settle();
		end
	endtask

	// ------------------------------------------------------------------
	// write checker and receiver stalls
	// ------------------------------------------------------------------
	always @(posedge clk) begin : write_monitor
		fb_write_t exp_w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_writes.size() == 0) begin
				err_count++;
				$display("%0t: stray write, expected none, got addr %h rgb %h last %b",
					$time, write_address, pixel_rgb, last_write);
			end else begin
				exp_w = pending_writes.pop_front();
				if (write_address !== exp_w.addr) begin
					err_count++;
					$display("%0t: write_address expected %h got %h",
						$time, exp_w.addr, write_address);
				end
				if (pixel_rgb !== exp_w.rgb) begin
					err_count++;
					$display("%0t: pixel_rgb expected %h got %h", $time, exp_w.rgb, pixel_rgb);
				end
				if (last_write !== exp_w.is_last) begin
					err_count++;
					$display("%0t: last_write expected %b got %b",
						$time, exp_w.is_last, last_write);
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if ($urandom_range(99) < stall_pct) begin
			stall_left = idle_len() - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_palette();
		test_scale_extremes();
		test_clipping();
		test_spare_index();
		test_random_traffic();
		if (err_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(RUN_LIMIT_NS);
		$display("Simulation FAILED");
		$finish;
	end

endmodule

[files.f]
sv/piuw_pkg.sv
sv/piuw_cfg.sv
sv/piuw_ctrl.sv
sv/piuw_dp.sv
sv/palette_integer_upscale_writer_unit.sv
bench/palette_integer_upscale_writer_unit_tb.sv
